>>> rtl/qbd_pkg.sv
// Shared types, widths and helpers for the quorum binary denoiser.
// Used by the interfaces and all modules of the block; depends on nothing.
package qbd_pkg;

    localparam int PATCH_W     = 64;
    localparam int PATCH_BITS  = 64;
    localparam int COUNT_BITS  = 24;
    localparam int NUM_BINS    = PATCH_BITS + 1;
    localparam int QW          = $clog2(NUM_BINS);
    localparam int QSUM_W      = 7;
    localparam int THRESH_W    = 17;
    localparam int FRAC_BITS   = 16;
    localparam int ACTION_W    = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int GROUP_BITS  = 8;
    localparam int GROUPS      = PATCH_W / GROUP_BITS;

    localparam logic [PATCH_W-1:0] PATCH_MASK = {PATCH_W{1'b1}} >> (PATCH_W - PATCH_BITS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_COUNT  = 2'd1,
        ACT_DECIDE = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESH_ZERO = 1'b0,
        REG_THRESH_ONE  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic          clear;
        logic          count;
        logic          z;
        logic [QW-1:0] q;
    } t_hist_op;

    function automatic logic [QW-1:0] count_ones(input logic [PATCH_W-1:0] v);
        logic [3:0] grp [GROUPS];
        logic [6:0] sum;
        sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            grp[g] = '0;
            for (int b = 0; b < GROUP_BITS; b++) begin
                grp[g] = grp[g] + 4'(v[g*GROUP_BITS + b]);
            end
        end
        for (int g = 0; g < GROUPS; g++) begin
            sum = sum + 7'(grp[g]);
        end
        return QW'(sum);
    endfunction

endpackage

>>> rtl/qbd_in_if.sv
// Pixel input channel of the denoiser: valid, ready and one pixel beat.
// Depends on qbd_pkg for field widths.
interface qbd_in_if import qbd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [PATCH_W-1:0]  patch_bits;
    logic                center_pixel;

    modport source (output valid, output action, output patch_bits, output center_pixel,
                    input ready);
    modport sink   (input valid, input action, input patch_bits, input center_pixel,
                    output ready);
endinterface

>>> rtl/qbd_out_if.sv
// Result output channel of the denoiser: valid, ready and one decision beat.
// Depends on qbd_pkg for field widths.
interface qbd_out_if import qbd_pkg::*;;
    logic              valid;
    logic              ready;
    logic              decided_pixel;
    logic              pixel_changed;
    logic [QSUM_W-1:0] quorum_sum;

    modport source (output valid, output decided_pixel, output pixel_changed,
                    output quorum_sum, input ready);
    modport sink   (input valid, input decided_pixel, input pixel_changed,
                    input quorum_sum, output ready);
endinterface

>>> rtl/qbd_hist.sv
// Per-quorum histogram memories with valid bits, registered read and write forwarding.
// Depends on qbd_pkg.
module qbd_hist import qbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [QW-1:0]         i_rd_q,
    input  t_hist_op              i_op,
    output logic [COUNT_BITS-1:0] o_total,
    output logic [COUNT_BITS-1:0] o_ones
);

    logic [COUNT_BITS-1:0] r_mem_total [NUM_BINS];
    logic [COUNT_BITS-1:0] r_mem_ones  [NUM_BINS];
    logic [NUM_BINS-1:0]   r_valid;
    logic [COUNT_BITS-1:0] r_rd_total;
    logic [COUNT_BITS-1:0] r_rd_ones;
    logic                  r_rd_valid;
    logic                  r_byp;
    logic [COUNT_BITS-1:0] r_byp_total;
    logic [COUNT_BITS-1:0] r_byp_ones;
    logic [COUNT_BITS-1:0] n_total;
    logic [COUNT_BITS-1:0] n_ones;

    always_comb begin
        if (r_byp) begin
            o_total = r_byp_total;
            o_ones  = r_byp_ones;
        end else if (r_rd_valid) begin
            o_total = r_rd_total;
            o_ones  = r_rd_ones;
        end else begin
            o_total = '0;
            o_ones  = '0;
        end
    end

    always_comb begin
        n_total = (o_total == {COUNT_BITS{1'b1}}) ? o_total : o_total + COUNT_BITS'(1);
        if (i_op.z && (o_ones != {COUNT_BITS{1'b1}})) begin
            n_ones = o_ones + COUNT_BITS'(1);
        end else begin
            n_ones = o_ones;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_op.count) begin
            r_mem_total[i_op.q] <= n_total;
            r_mem_ones[i_op.q]  <= n_ones;
        end
        if (i_en) begin
            r_rd_total  <= r_mem_total[i_rd_q];
            r_rd_ones   <= r_mem_ones[i_rd_q];
            r_byp_total <= i_op.clear ? '0 : n_total;
            r_byp_ones  <= i_op.clear ? '0 : n_ones;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else if (i_en) begin
            if (i_op.clear) begin
                r_valid <= '0;
            end else if (i_op.count) begin
                r_valid[i_op.q] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_q];
            r_byp      <= i_op.clear || (i_op.count && (i_op.q == i_rd_q));
        end
    end

endmodule

>>> rtl/qbd_decide.sv
// Minimum-risk decision for one pixel from its histogram bin and the thresholds.
// Depends on qbd_pkg.
module qbd_decide import qbd_pkg::*; (
    input  logic [COUNT_BITS-1:0] i_total,
    input  logic [COUNT_BITS-1:0] i_ones,
    input  logic                  i_z,
    input  logic [THRESH_W-1:0]   i_thresh_zero,
    input  logic [THRESH_W-1:0]   i_thresh_one,
    output logic                  o_bit
);

    logic [COUNT_BITS-1:0]          zeros;
    logic [COUNT_BITS-1:0]          num;
    logic [THRESH_W-1:0]            thr;
    logic [THRESH_W+COUNT_BITS-1:0] lhs;
    logic [THRESH_W+COUNT_BITS-1:0] rhs;
    logic                           pass;

    always_comb begin
        zeros = (i_ones > i_total) ? '0 : i_total - i_ones;
        num   = i_z ? i_ones : zeros;
        thr   = i_z ? i_thresh_one : i_thresh_zero;
        lhs   = (THRESH_W+COUNT_BITS)'({num, {FRAC_BITS{1'b0}}});
        rhs   = (THRESH_W+COUNT_BITS)'(thr) * (THRESH_W+COUNT_BITS)'(i_total);
        pass  = (lhs >= rhs);
        if (i_total == '0) begin
            o_bit = !i_z;
        end else begin
            o_bit = i_z ? pass : !pass;
        end
    end

endmodule

>>> rtl/quorum_binary_denoiser.sv
// Quorum binary denoiser top level: input register, popcount and histogram access, result register.
// A decide beat goes from the input register to the r_b register, then to the result register.
// Throughput: one beat per cycle; the whole pipeline stalls only while the result register is held.
// Reset: thresholds go to zero and the valid bits empty the histogram at once; no clearing pass.
// Depends on qbd_pkg, qbd_in_if, qbd_out_if, qbd_hist and qbd_decide.
module quorum_binary_denoiser import qbd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    qbd_in_if.sink               i_pix,
    qbd_out_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [THRESH_W-1:0]  i_cfg_data
);

    logic                  en;
    logic [THRESH_W-1:0]   r_thresh_zero;
    logic [THRESH_W-1:0]   r_thresh_one;
    logic                  r_a_valid;
    logic [ACTION_W-1:0]   r_a_action;
    logic [PATCH_W-1:0]    r_a_patch;
    logic                  r_a_z;
    logic [QW-1:0]         a_q;
    logic                  r_b_valid;
    logic [ACTION_W-1:0]   r_b_action;
    logic [QW-1:0]         r_b_q;
    logic                  r_b_z;
    t_hist_op              hist_op;
    logic [COUNT_BITS-1:0] hist_total;
    logic [COUNT_BITS-1:0] hist_ones;
    logic                  dec_bit;
    logic                  r_out_valid;
    logic                  r_out_bit;
    logic                  r_out_changed;
    logic [QSUM_W-1:0]     r_out_q;

    assign en          = !r_out_valid || o_res.ready;
    assign i_pix.ready = en;
    assign a_q         = count_ones(r_a_patch & PATCH_MASK);

    always_comb begin
        hist_op.clear = r_b_valid && (r_b_action == ACT_CLEAR);
        hist_op.count = r_b_valid && (r_b_action == ACT_COUNT);
        hist_op.z     = r_b_z;
        hist_op.q     = r_b_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh_zero <= '0;
            r_thresh_one  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_THRESH_ZERO: begin
                    r_thresh_zero <= i_cfg_data;
                end
                REG_THRESH_ONE: begin
                    r_thresh_one <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_pix.valid;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid && (r_b_action == ACT_DECIDE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_action    <= i_pix.action;
            r_a_patch     <= i_pix.patch_bits;
            r_a_z         <= i_pix.center_pixel;
            r_b_action    <= r_a_action;
            r_b_q         <= a_q;
            r_b_z         <= r_a_z;
            r_out_bit     <= dec_bit;
            r_out_changed <= dec_bit ^ r_b_z;
            r_out_q       <= QSUM_W'(r_b_q);
        end
    end

    qbd_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rd_q  (a_q),
        .i_op    (hist_op),
        .o_total (hist_total),
        .o_ones  (hist_ones)
    );

    qbd_decide u_decide (
        .i_total       (hist_total),
        .i_ones        (hist_ones),
        .i_z           (r_b_z),
        .i_thresh_zero (r_thresh_zero),
        .i_thresh_one  (r_thresh_one),
        .o_bit         (dec_bit)
    );

    assign o_res.valid         = r_out_valid;
    assign o_res.decided_pixel = r_out_bit;
    assign o_res.pixel_changed = r_out_changed;
    assign o_res.quorum_sum    = r_out_q;

    a_result_only_for_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_b_valid && (r_b_action == ACT_DECIDE)))
        else $error("result appeared without a decide beat");

    a_ones_within_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (hist_ones <= hist_total))
        else $error("histogram ones count exceeds total count");

    a_empty_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && $past(en && r_b_valid && (r_b_action == ACT_CLEAR)))
            |-> (hist_total == '0))
        else $error("bin not empty right after a clear");

    a_quorum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> (r_b_q <= QW'(PATCH_BITS)))
        else $error("quorum exceeds patch size");

endmodule
